>>> design/mbss_pkg.sv
`timescale 1ns / 1ps

package mbss_pkg;

  // Signature storage is fixed by the register layout: two 64-bit words.
  localparam int SIG_BYTES  = 16;
  localparam int SIG_IDX_W  = 4;

  // Output address field width.
  localparam int OUT_ADDR_W = 48;

  // Configuration port geometry: 64-bit registers at 8-byte strides.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_IDX_LO = 3;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_CARE_MASK      = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_RESULT_OFFSET  = 3'd4,
    REG_BASE_ADDRESS   = 3'd5,
    REG_FIND_ALL       = 3'd6
  } reg_idx_t;

  // One streamed memory byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       access_fault;
    logic       last_byte;
  } in_item_t;

  // One scan result.
  typedef struct packed {
    logic                  found;
    logic [OUT_ADDR_W-1:0] match_address;
    logic                  end_of_scan;
  } out_item_t;

endpackage

>>> design/masked_byte_signature_scan_top.sv
`timescale 1ns / 1ps

// Masked byte signature scanner. The block takes one memory byte per cycle
// while its results are taken: every accepted item goes through an
// input register, one parallel compare of the whole byte window against the
// signature, and lands in the result register, so a result (if the byte
// causes one) is captured in the result register when the input register
// moves on, which it does whenever the result slot is free. The result
// register lets the next byte be accepted while a result still waits to be
// taken; the pipe stalls only when both the input register and the result
// register are occupied and the result is not taken. The byte window is held
// in MAX_PATTERN_BYTES flip-flop taps, and match addresses are computed modulo
// 2^ADDRESS_BITS. Configuration (signature, care mask, length, offset, base
// address, first-only or find-all) must be written over the APB port only while
// no item is in flight; the block itself does not enforce this.
module masked_byte_signature_scan_top #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int ADDRESS_BITS      = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  mbss_pkg::in_item_t                in_item,

  output logic                              out_valid,
  input  logic                              out_ready,
  output mbss_pkg::out_item_t               out_item,

  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mbss_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [mbss_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [mbss_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  import mbss_pkg::*;

  localparam int WIN  = MAX_PATTERN_BYTES;
  localparam int LENW = $clog2(WIN + 1);

  // Configuration registers.
  logic [63:0]           pat_lo_r, pat_lo_nxt;
  logic [63:0]           pat_hi_r, pat_hi_nxt;
  logic [15:0]           care_r, care_nxt;
  logic [4:0]            plen_r, plen_nxt;
  logic [3:0]            roff_r, roff_nxt;
  logic [OUT_ADDR_W-1:0] base_r, base_nxt;
  logic                  find_all_r, find_all_nxt;

  // Input register.
  logic                  s1_valid_r, s1_valid_nxt;
  in_item_t              s1_item_r, s1_item_nxt;

  // Scan state.
  logic [7:0]            win_r [WIN];
  logic [7:0]            win_nxt [WIN];
  logic [LENW-1:0]       vrun_r, vrun_nxt;
  logic [ADDRESS_BITS-1:0] bidx_r, bidx_nxt;
  logic                  seen_r, seen_nxt;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic                  cfg_wr;
  reg_idx_t              cfg_idx;
  logic [7:0]            sig [SIG_BYTES];
  logic [LENW-1:0]       len_eff;
  logic                  out_free;
  logic                  s1_adv;
  logic [WIN-1:0]        byte_ok;
  logic                  hit;
  logic                  report_en;
  logic                  produce;
  out_item_t             result;
  logic [ADDRESS_BITS-1:0] start_addr;
  logic [ADDRESS_BITS-1:0] match_addr;

  // Configuration port: always ready, write on the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:CFG_IDX_LO]);

  always_comb begin
    pat_lo_nxt   = pat_lo_r;
    pat_hi_nxt   = pat_hi_r;
    care_nxt     = care_r;
    plen_nxt     = plen_r;
    roff_nxt     = roff_r;
    base_nxt     = base_r;
    find_all_nxt = find_all_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PATTERN_LOW:    pat_lo_nxt   = cfg_pwdata;
        REG_PATTERN_HIGH:   pat_hi_nxt   = cfg_pwdata;
        REG_CARE_MASK:      care_nxt     = cfg_pwdata[15:0];
        REG_PATTERN_LENGTH: plen_nxt     = cfg_pwdata[4:0];
        REG_RESULT_OFFSET:  roff_nxt     = cfg_pwdata[3:0];
        REG_BASE_ADDRESS:   base_nxt     = cfg_pwdata[OUT_ADDR_W-1:0];
        REG_FIND_ALL:       find_all_nxt = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (cfg_idx)
      REG_PATTERN_LOW:    cfg_prdata = pat_lo_r;
      REG_PATTERN_HIGH:   cfg_prdata = pat_hi_r;
      REG_CARE_MASK:      cfg_prdata = CFG_DATA_W'(care_r);
      REG_PATTERN_LENGTH: cfg_prdata = CFG_DATA_W'(plen_r);
      REG_RESULT_OFFSET:  cfg_prdata = CFG_DATA_W'(roff_r);
      REG_BASE_ADDRESS:   cfg_prdata = CFG_DATA_W'(base_r);
      REG_FIND_ALL:       cfg_prdata = CFG_DATA_W'(find_all_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // Signature bytes, byte 0 in the low bits of the low word.
  always_comb begin
    for (int i = 0; i < SIG_BYTES; i++) begin
      sig[i] = (i < 8) ? pat_lo_r[(i % 8) * 8 +: 8] : pat_hi_r[(i % 8) * 8 +: 8];
    end
  end

  // A length of zero acts as one; anything above the window acts as the window.
  always_comb begin
    len_eff = LENW'(WIN);
    if (plen_r == '0) begin
      len_eff = LENW'(1);
    end else if (plen_r <= 5'(WIN)) begin
      len_eff = LENW'(plen_r);
    end
  end

  // Handshake: the input register moves on whenever the result slot is free.
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_comb begin
    s1_item_nxt  = s1_item_r;
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_item_nxt  = in_item;
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Window shift; a faulting byte empties the window.
  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      if (s1_item_r.access_fault) begin
        win_nxt[j] = '0;
      end else if (j == 0) begin
        win_nxt[j] = s1_item_r.data_byte;
      end else begin
        win_nxt[j] = win_r[(j == 0) ? 0 : j - 1];
      end
    end
    if (s1_item_r.access_fault) begin
      vrun_nxt = '0;
    end else if (vrun_r < LENW'(WIN)) begin
      vrun_nxt = vrun_r + LENW'(1);
    end else begin
      vrun_nxt = vrun_r;
    end
  end

  // Parallel compare: window tap j lines up with signature byte len-1-j.
  always_comb begin
    logic [SIG_IDX_W-1:0] sidx;
    for (int j = 0; j < WIN; j++) begin
      sidx = SIG_IDX_W'(len_eff - LENW'(1) - LENW'(j));
      if (LENW'(j) < len_eff) begin
        byte_ok[j] = !care_r[sidx] || (win_nxt[j] == sig[sidx]);
      end else begin
        byte_ok[j] = 1'b1;
      end
    end
    hit = !s1_item_r.access_fault && (vrun_nxt >= len_eff) && (&byte_ok);
  end

  // Match address: region base plus start index plus the marked offset.
  assign start_addr = bidx_r - ADDRESS_BITS'(len_eff - LENW'(1));
  assign match_addr = ADDRESS_BITS'(base_r) + start_addr + ADDRESS_BITS'(roff_r);

  // Result selection.
  assign report_en = find_all_r || !seen_r;

  always_comb begin
    result  = '0;
    produce = 1'b0;
    if (hit && report_en) begin
      produce              = 1'b1;
      result.found         = 1'b1;
      result.match_address = OUT_ADDR_W'(match_addr);
      result.end_of_scan   = find_all_r ? s1_item_r.last_byte : 1'b1;
    end else if (s1_item_r.last_byte && report_en) begin
      produce            = 1'b1;
      result.end_of_scan = 1'b1;
    end
  end

  // Region state; the last byte sends everything back to the start.
  always_comb begin
    bidx_nxt = bidx_r;
    seen_nxt = seen_r;
    if (s1_adv) begin
      if (s1_item_r.last_byte) begin
        bidx_nxt = '0;
        seen_nxt = 1'b0;
      end else begin
        bidx_nxt = bidx_r + ADDRESS_BITS'(1);
        if (hit && report_en && !find_all_r) begin
          seen_nxt = 1'b1;
        end
      end
    end
  end

  // Result register.
  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = produce;
      out_item_nxt  = result;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      care_r      <= '0;
      plen_r      <= 5'd1;
      roff_r      <= '0;
      base_r      <= '0;
      find_all_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      vrun_r      <= '0;
      bidx_r      <= '0;
      seen_r      <= 1'b0;
    end else begin
      pat_lo_r    <= pat_lo_nxt;
      pat_hi_r    <= pat_hi_nxt;
      care_r      <= care_nxt;
      plen_r      <= plen_nxt;
      roff_r      <= roff_nxt;
      base_r      <= base_nxt;
      find_all_r  <= find_all_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        vrun_r <= s1_item_r.last_byte ? '0 : vrun_nxt;
      end
      bidx_r      <= bidx_nxt;
      seen_r      <= seen_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    out_item_r <= out_item_nxt;
    if (s1_adv) begin
      for (int j = 0; j < WIN; j++) begin
        win_r[j] <= win_nxt[j];
      end
    end
  end

endmodule

>>> design/mbss_checker.sv
`timescale 1ns / 1ps

module mbss_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mbss_pkg::out_item_t out_item
);

  import mbss_pkg::*;

  // A stalled result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  // A not-found result always closes the region.
  a_miss_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |-> out_item.end_of_scan)
    else $error("not-found result without end of scan");

  // A not-found result carries a zero address.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |-> out_item.match_address == '0)
    else $error("not-found result with nonzero address");

  // Coming out of reset the pipe is empty and ready for an item.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipe not empty after reset");

endmodule

bind masked_byte_signature_scan_top mbss_checker u_mbss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
